FILE: rtl/core/smfc_pkg.sv
// smfc_pkg: shared types for the sorted multiset floor/ceiling block
// command and status codes, controller state, cell control and hit records
// no dependencies
`default_nettype none

package smfc_pkg;

    localparam int VALUE_W = 32;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_ERASE  = 2'd1,
        CMD_CEIL   = 2'd2,
        CMD_FLOOR  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic ins_en;
        logic del_en;
        t_cmd cmd;
    } t_cell_ctl;

    typedef struct packed {
        logic                      hit;
        logic signed [VALUE_W-1:0] value;
    } t_hit;

endpackage

`default_nettype wire

FILE: rtl/core/smfc_cell.sv
// smfc_cell: one slot of the sorted row, holds a single value
// compares against the key, shifts with its neighbors, flags a query hit
// depends on smfc_pkg
`default_nettype none

module smfc_cell (
    input  wire logic                               i_clk,
    input  wire smfc_pkg::t_cell_ctl                i_ctl,
    input  wire logic signed [smfc_pkg::VALUE_W-1:0] i_key,
    input  wire logic                               i_valid,
    input  wire logic signed [smfc_pkg::VALUE_W-1:0] i_left_value,
    input  wire logic                               i_left_le,
    input  wire logic                               i_left_ge,
    input  wire logic signed [smfc_pkg::VALUE_W-1:0] i_right_value,
    input  wire logic                               i_right_valid,
    input  wire logic                               i_right_le,
    output logic signed [smfc_pkg::VALUE_W-1:0]      o_value,
    output logic                                    o_le,
    output logic                                    o_ge,
    output smfc_pkg::t_hit                          o_hit
);
    import smfc_pkg::*;

    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] n_value;
    logic                      w_le;
    logic                      w_ge;
    logic                      w_hit;

    assign w_le = (r_value <= i_key);
    assign w_ge = (r_value >= i_key);

    always_comb begin
        n_value = r_value;
        if (i_ctl.ins_en) begin
            if (i_valid && w_le) begin
                n_value = r_value;
            end else if (i_left_le) begin
                n_value = i_key;
            end else begin
                n_value = i_left_value;
            end
        end else if (i_ctl.del_en && w_ge) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    always_comb begin
        case (i_ctl.cmd)
            CMD_INSERT: w_hit = 1'b0;
            CMD_ERASE:  w_hit = i_valid && w_le && w_ge && !i_left_ge;
            CMD_CEIL:   w_hit = i_valid && w_ge && !i_left_ge;
            CMD_FLOOR:  w_hit = i_valid && w_le && !(i_right_valid && i_right_le);
            default:    w_hit = 1'b0;
        endcase
    end

    assign o_value     = r_value;
    assign o_le        = w_le;
    assign o_ge        = w_ge;
    assign o_hit.hit   = w_hit;
    assign o_hit.value = w_hit ? r_value : '0;

endmodule

`default_nettype wire

FILE: rtl/core/smfc_tree.sv
// smfc_tree: registered or-reduction of the cell hit records
// the leaf records and every tree level are registered on the way to the root
// depends on smfc_pkg
`default_nettype none

module smfc_tree #(
    parameter int LEAVES = 64
) (
    input  wire logic                           i_clk,
    input  wire smfc_pkg::t_hit [LEAVES-1:0]    i_leaf,
    output smfc_pkg::t_hit                      o_root
);
    import smfc_pkg::*;

    t_hit r_node [1:2*LEAVES-1];

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < LEAVES; j++) begin
            r_node[LEAVES+j] <= i_leaf[j];
        end
        for (int k = 1; k < LEAVES; k++) begin
            r_node[k] <= r_node[2*k] | r_node[2*k+1];
        end
    end

    assign o_root = r_node[1];

endmodule

`default_nettype wire

FILE: rtl/core/sorted_multiset_floor_ceiling_top.sv
// sorted_multiset_floor_ceiling_top: sorted multiset with floor and ceiling queries
// a row of smfc_cell slots kept in ascending order plus an smfc_tree hit reduction
// depends on smfc_pkg, smfc_cell, smfc_tree
//
//  channel   signals                       transfer
//  command   start, i_command, i_value     start high and busy low at a clock edge
//  result    o_valid, o_status, o_answer   o_valid high for one cycle, always taken
//
// insert: finishes without waiting on the hit tree, all cells shift at once
// erase, ceiling, floor: the result waits for the hit to pass the registered hit tree
// busy stays high until the result cycle; the next command is taken in that cycle
// synchronous active-low reset empties the store; cell contents are not cleared
// the receiver cannot stall, each result is presented exactly once
`default_nettype none

module sorted_multiset_floor_ceiling_top #(
    parameter int CAPACITY = 64
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    input  wire logic [1:0]                         i_command,
    input  wire logic signed [smfc_pkg::VALUE_W-1:0] i_value,
    output logic                                    busy,
    output logic                                    o_valid,
    output logic [1:0]                              o_status,
    output logic signed [smfc_pkg::VALUE_W-1:0]      o_answer
);
    import smfc_pkg::*;

    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DEPTH    = $clog2(CAPACITY);
    localparam int LEAVES   = 1 << DEPTH;
    localparam int TREE_LAT = DEPTH + 1;
    localparam int WAIT_W   = $clog2(TREE_LAT + 1);

    t_state                    r_state;
    t_state                    n_state;
    t_cmd                      r_cmd;
    logic signed [VALUE_W-1:0] r_key;
    logic [CNT_W-1:0]          r_count;
    logic [WAIT_W-1:0]         r_wait;
    logic                      r_out_valid;
    t_status                   r_status;
    logic signed [VALUE_W-1:0] r_answer;

    logic                      w_accept;
    logic                      w_full;
    logic                      w_finish;
    t_status                   w_status;
    logic signed [VALUE_W-1:0] w_answer;
    t_cell_ctl                 w_ctl;
    t_hit                      w_root;

    logic signed [VALUE_W-1:0] w_value [CAPACITY];
    logic                      w_le    [CAPACITY];
    logic                      w_ge    [CAPACITY];
    logic                      w_valid [CAPACITY];
    t_hit [LEAVES-1:0]         w_leaf;

    assign w_accept = start && !busy;
    assign w_full   = (r_count == CNT_W'(CAPACITY));

    // cell row
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [VALUE_W-1:0] w_lv;
        logic                      w_lle;
        logic                      w_lge;
        logic signed [VALUE_W-1:0] w_rv;
        logic                      w_rvalid;
        logic                      w_rle;
        t_hit                      w_hit;

        assign w_valid[i] = (CNT_W'(i) < r_count);

        if (i == 0) begin : g_first
            assign w_lv  = r_key;
            assign w_lle = 1'b1;
            assign w_lge = 1'b0;
        end else begin : g_mid_left
            assign w_lv  = w_value[i-1];
            assign w_lle = w_le[i-1];
            assign w_lge = w_ge[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign w_rv     = '0;
            assign w_rvalid = 1'b0;
            assign w_rle    = 1'b0;
        end else begin : g_mid_right
            assign w_rv     = w_value[i+1];
            assign w_rvalid = w_valid[i+1];
            assign w_rle    = w_le[i+1];
        end

        smfc_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_key         (r_key),
            .i_valid       (w_valid[i]),
            .i_left_value  (w_lv),
            .i_left_le     (w_lle),
            .i_left_ge     (w_lge),
            .i_right_value (w_rv),
            .i_right_valid (w_rvalid),
            .i_right_le    (w_rle),
            .o_value       (w_value[i]),
            .o_le          (w_le[i]),
            .o_ge          (w_ge[i]),
            .o_hit         (w_hit)
        );

        assign w_leaf[i] = w_hit;
    end

    for (genvar j = CAPACITY; j < LEAVES; j++) begin : g_pad
        assign w_leaf[j] = '0;
    end

    smfc_tree #(
        .LEAVES (LEAVES)
    ) u_tree (
        .i_clk  (i_clk),
        .i_leaf (w_leaf),
        .o_root (w_root)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_finish) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the controller
    always_comb begin
        busy       = 1'b0;
        w_finish   = 1'b0;
        w_ctl.cmd  = r_cmd;
        w_ctl.ins_en = 1'b0;
        w_ctl.del_en = 1'b0;
        w_status   = ST_OK;
        w_answer   = '0;
        case (r_state)
            S_IDLE: begin
                busy = 1'b0;
            end
            S_SCAN: begin
                busy = 1'b1;
                if (r_cmd == CMD_INSERT) begin
                    if (r_wait == '0) begin
                        w_finish     = 1'b1;
                        w_ctl.ins_en = !w_full;
                        w_status     = w_full ? ST_FULL : ST_OK;
                    end
                end else if (r_wait == WAIT_W'(TREE_LAT)) begin
                    w_finish = 1'b1;
                    w_status = w_root.hit ? ST_OK : ST_NOT_FOUND;
                    if (r_cmd == CMD_ERASE) begin
                        w_ctl.del_en = w_root.hit;
                    end else begin
                        w_answer = w_root.hit ? w_root.value : '0;
                    end
                end
            end
            default: busy = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_wait      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= w_finish;
            if (w_accept) begin
                r_wait <= '0;
            end else if (r_state == S_SCAN && !w_finish) begin
                r_wait <= r_wait + 1'b1;
            end
            if (w_ctl.ins_en) begin
                r_count <= r_count + 1'b1;
            end else if (w_ctl.del_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= t_cmd'(i_command);
            r_key <= i_value;
        end
        if (w_finish) begin
            r_status <= w_status;
            r_answer <= w_answer;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_status;
    assign o_answer = r_answer;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |-> busy)
        else $error("result produced while idle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("command transfer did not start work");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.ins_en |=> r_count == $past(r_count) + 1'b1)
        else $error("insert did not grow the store");

    a_no_shift_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ctl.ins_en && w_ctl.del_en))
        else $error("insert and erase shift in one cycle");

endmodule

`default_nettype wire
